// ===== design/prefix_preserving_addr_anonymizer_assert.svh =====
// assertion macros for the prefix-preserving address anonymizer
// used by the top level only; no other dependencies
`ifndef PREFIX_PRESERVING_ADDR_ANONYMIZER_ASSERT_SVH
`define PREFIX_PRESERVING_ADDR_ANONYMIZER_ASSERT_SVH
`ifndef SYNTHESIS
`define PPAA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PPAA_ASSERT_RST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PPAA_ASSERT(lbl, clk, rst, prop, msg)
`define PPAA_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

// ===== design/ppaa_pkg.sv =====
// shared types, constants and aes helpers for the address anonymizer
// no dependencies
`default_nettype none
package ppaa_pkg;
   localparam int MaxBytes = 16;
   localparam int LastRound = 10;

   localparam logic [0:0] CSR_KEY_HI = 1'b0;
   localparam logic [0:0] CSR_KEY_LO = 1'b1;

   typedef struct packed {
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
      logic [4:0]  num_bytes;
   } req_type;

   typedef struct packed {
      logic [63:0] anon_hi;
      logic [63:0] anon_lo;
   } rsp_type;

   typedef struct packed {
      logic start;
   } aes_ctl_type;

   typedef struct packed {
      logic done;
      logic msb;
   } aes_sts_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RUN,
      ST_FINISH
   } state_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   // multiply by x in gf(2^8)
   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // round constant for rounds 1..10
   function automatic logic [7:0] rcon(input logic [3:0] rnd);
      logic [7:0] r;
      case (rnd)
         4'd1: r = 8'h01;
         4'd2: r = 8'h02;
         4'd3: r = 8'h04;
         4'd4: r = 8'h08;
         4'd5: r = 8'h10;
         4'd6: r = 8'h20;
         4'd7: r = 8'h40;
         4'd8: r = 8'h80;
         4'd9: r = 8'h1b;
         4'd10: r = 8'h36;
         default: r = 8'h00;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

// ===== design/prefix_preserving_addr_anonymizer.sv =====
// prefix-preserving address anonymizer: key registers, bit sequencer, result register
// depends on ppaa_pkg, ppaa_aes and the assertion macro header
//
// usage:
//   csr channel: csr_valid/csr_ready with csr_index (0 = key_hi, 1 = key_lo)
//   and csr_data; always ready, write only while the block is idle.
//   req channel: req_valid/req_stall with req_data (address and length).
//   rsp channel: rsp_valid/rsp_stall with rsp_data (anonymized address).
//   each of the 8*num_bytes bit positions runs one aes-128 encryption on the
//   shared round core: a load step, ten rounds and a handoff step for each bit.
//   one item is worked on at a time; req_stall is high from acceptance until
//   the result moves into the output register.
//   the output register lets a new item start while a result waits; when the
//   receiver stalls, the result holds and a following finished item waits.
//   reset (synchronous, active high) clears keys to zero and empties the block.
`default_nettype none
`include "prefix_preserving_addr_anonymizer_assert.svh"
module prefix_preserving_addr_anonymizer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [0:0]        csr_index,
   input  wire logic [63:0]       csr_data,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ppaa_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ppaa_pkg::rsp_type      rsp_data
);
   import ppaa_pkg::*;

   state_type    state_ff, state_in;
   logic [127:0] key_ff;
   logic [127:0] addr_ff, mask_ff, onehot_ff, pad_ff;
   logic [7:0]   bits_ff, count_ff;
   logic         rsp_valid_ff;
   rsp_type      rsp_ff;
   aes_ctl_type  aes_ctl;
   aes_sts_type  aes_sts;
   logic         req_xfer, load_out, out_free, step;
   logic [4:0]   n_sat;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign n_sat     = (req_data.num_bytes > 5'(MaxBytes)) ? 5'(MaxBytes) : req_data.num_bytes;

   // key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_KEY_HI: key_ff[127:64] <= csr_data;
            CSR_KEY_LO: key_ff[63:0]   <= csr_data;
            default:    key_ff         <= key_ff;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_xfer) state_in = ST_CHECK;
         ST_CHECK:  state_in = (count_ff == bits_ff) ? ST_FINISH : ST_RUN;
         ST_RUN:    if (aes_sts.done) state_in = ST_CHECK;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      aes_ctl.start = 1'b0;
      step          = 1'b0;
      load_out      = 1'b0;
      case (state_ff)
         ST_CHECK:  aes_ctl.start = (count_ff != bits_ff);
         ST_RUN:    step          = aes_sts.done;
         ST_FINISH: load_out      = out_free;
         default:   ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // per-item working registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         addr_ff   <= {req_data.addr_hi, req_data.addr_lo};
         bits_ff   <= {n_sat, 3'b000};
         count_ff  <= '0;
         mask_ff   <= '0;
         onehot_ff <= {1'b1, 127'b0};
         pad_ff    <= '0;
      end else if (step) begin
         count_ff  <= count_ff + 8'd1;
         mask_ff   <= {1'b1, mask_ff[127:1]};
         onehot_ff <= {1'b0, onehot_ff[127:1]};
         pad_ff    <= pad_ff | (aes_sts.msb ? onehot_ff : '0);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load_out) begin
         {rsp_ff.anon_hi, rsp_ff.anon_lo} <= (addr_ff ^ pad_ff) & mask_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   ppaa_aes u_aes (
      .clock    (clock),
      .reset    (reset),
      .ctl      (aes_ctl),
      .block_in (addr_ff & mask_ff),
      .key_in   (key_ff),
      .sts      (aes_sts)
   );

   `PPAA_ASSERT(a_req_to_check, clock, reset, req_xfer |=> state_ff == ST_CHECK, "accept not followed by check")
   `PPAA_ASSERT(a_done_in_run, clock, reset, aes_sts.done |-> state_ff == ST_RUN, "aes done outside run")
   `PPAA_ASSERT(a_count_bound, clock, reset, state_ff != ST_IDLE |-> count_ff <= bits_ff, "bit count overran length")
   `PPAA_ASSERT(a_load_free, clock, reset, load_out |-> !(rsp_valid_ff && rsp_stall), "result overwritten while stalled")
endmodule
`default_nettype wire

// ===== design/ppaa_aes.sv =====
// iterative aes-128 encryption core: one round per cycle, round keys on the fly
// depends on ppaa_pkg
`default_nettype none
module ppaa_aes (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ppaa_pkg::aes_ctl_type ctl,
   input  wire logic [127:0]          block_in,
   input  wire logic [127:0]          key_in,
   output ppaa_pkg::aes_sts_type      sts
);
   import ppaa_pkg::*;

   logic [127:0] state_ff, state_in;
   logic [127:0] rk_ff, rk_in;
   logic [3:0]   round_ff, round_in;
   logic         active_ff, active_in;
   logic         done_ff, done_in;
   logic [127:0] shifted, mixed, rk_next;
   logic         last;

   assign last = (round_ff == 4'(LastRound));

   // subbytes and shiftrows
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            shifted[127 - 8 * (r + 4 * c) -: 8] =
               SBOX[state_ff[127 - 8 * (r + 4 * ((c + r) & 3)) -: 8]];
         end
      end
   end

   // mixcolumns, skipped in the final round
   always_comb begin
      logic [7:0] a0, a1, a2, a3, all;
      mixed = shifted;
      for (int c = 0; c < 4; c++) begin
         a0  = shifted[127 - 32 * c -: 8];
         a1  = shifted[119 - 32 * c -: 8];
         a2  = shifted[111 - 32 * c -: 8];
         a3  = shifted[103 - 32 * c -: 8];
         all = a0 ^ a1 ^ a2 ^ a3;
         mixed[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
         mixed[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
         mixed[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
         mixed[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
      end
      if (last) begin
         mixed = shifted;
      end
   end

   // next round key
   always_comb begin
      logic [31:0] t;
      t = {SBOX[rk_ff[23:16]] ^ rcon(round_ff), SBOX[rk_ff[15:8]],
           SBOX[rk_ff[7:0]], SBOX[rk_ff[31:24]]};
      rk_next[127:96] = rk_ff[127:96] ^ t;
      rk_next[95:64]  = rk_ff[95:64] ^ rk_next[127:96];
      rk_next[63:32]  = rk_ff[63:32] ^ rk_next[95:64];
      rk_next[31:0]   = rk_ff[31:0] ^ rk_next[63:32];
   end

   // round sequencing
   always_comb begin
      state_in  = state_ff;
      rk_in     = rk_ff;
      round_in  = round_ff;
      active_in = active_ff;
      done_in   = 1'b0;
      if (ctl.start) begin
         state_in  = block_in ^ key_in;
         rk_in     = key_in;
         round_in  = 4'd1;
         active_in = 1'b1;
      end else if (active_ff) begin
         state_in = mixed ^ rk_next;
         rk_in    = rk_next;
         round_in = round_ff + 4'd1;
         if (last) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      rk_ff    <= rk_in;
      round_ff <= round_in;
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   assign sts.done = done_ff;
   assign sts.msb  = state_ff[127];
endmodule
`default_nettype wire
